### rtl/delta_timer_queue_macros.svh
// ----------------------------------------------------------------------------
// Delta timer queue assertion macros
// Shared shorthand for the concurrent checks on the queue's ports.
// ----------------------------------------------------------------------------
`ifndef DELTA_TIMER_QUEUE_MACROS_SVH
`define DELTA_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DTQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("delta_timer_queue check failed");

// Next-cycle implication, disabled during reset
`define DTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("delta_timer_queue check failed");

`endif

### rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Operation and status codes of the delta timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_TICK     = 2'd1,
      OP_TAKE_DUE = 2'd2,
      OP_REMOVE   = 2'd3
   } op_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

### rtl/dtq_ram.sv
// ----------------------------------------------------------------------------
// dtq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/delta_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_timer_queue
// Sleep-timer queue keeping handles in expiry order as a delta list.
// ----------------------------------------------------------------------------
// Usage: one request word (operation, handle, delay_ticks) goes in on the req_
// channel and exactly one response word comes out on the rsp_ channel. Entries
// live in one RAM word each (delta and handle) and are walked by a small
// sequencer with one read and one write port.
// Steps: a full queue add, or a tick, take-due or remove on an empty queue,
// goes straight to the response; an add on an empty queue writes its entry
// first. A tick or take-due that does not release touches only the head; one
// that releases shifts the rest down. An add walks the entries it passes and
// shifts up those it moves; a remove searches and shifts likewise.
// Throughput: one word at a time; req_stall is high while an item is in work.
// The single RAM port pair sets the pace of every walk and shift.
// Reset clears the entry count and the response valid; the RAM is not cleared,
// only counted entries are ever read. A stalled response holds in its output
// register, and the next request may be taken meanwhile; its result waits
// until the held word is taken.
// ----------------------------------------------------------------------------
module delta_timer_queue
   import dtq_pkg::*;
#(
   parameter int CAPACITY     = 32,
   parameter int TICK_WIDTH   = 32,
   parameter int HANDLE_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_operation,
   input  logic [HANDLE_WIDTH-1:0]          req_handle,
   input  logic [TICK_WIDTH-1:0]            req_delay_ticks,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_released,
   output logic [HANDLE_WIDTH-1:0]          rsp_released_handle,
   output logic                             rsp_status,
   output logic                             rsp_queue_empty,
   output logic [$clog2(CAPACITY+1)-1:0]    rsp_entry_count
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int WORD_W = TICK_WIDTH + HANDLE_WIDTH;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);
   localparam logic [TICK_WIDTH-1:0] TICK_ONE = TICK_WIDTH'(1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_EVAL, ST_UP_RD, ST_UP_WR, ST_INSERT,
      ST_MERGE, ST_DN_RD, ST_DN_WR, ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [HANDLE_WIDTH-1:0] hnd_ff, hnd_in;
   logic [TICK_WIDTH-1:0]   delay_ff, delay_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        sh_ff, sh_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [WORD_W-1:0]       succ_ff, succ_in;
   logic                    link_ff, link_in;
   logic                    rel_ff, rel_in;
   logic [HANDLE_WIDTH-1:0] relh_ff, relh_in;
   logic                    status_ff, status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_rel_ff, rsp_rel_in;
   logic [HANDLE_WIDTH-1:0] rsp_relh_ff, rsp_relh_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;

   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr, ram_raddr;
   logic [WORD_W-1:0]       ram_wdata, ram_rdata;

   logic [TICK_WIDTH-1:0]   cur_delta, succ_delta;
   logic [HANDLE_WIDTH-1:0] cur_handle, succ_handle;
   logic [CNT_W-1:0]        idx_next, sh_dec;
   logic [TICK_WIDTH:0]     merge_sum;
   logic [TICK_WIDTH-1:0]   merge_sat;

   dtq_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Field views, index steps and the saturating merge adder
   assign cur_delta   = ram_rdata[WORD_W-1:HANDLE_WIDTH];
   assign cur_handle  = ram_rdata[HANDLE_WIDTH-1:0];
   assign succ_delta  = succ_ff[WORD_W-1:HANDLE_WIDTH];
   assign succ_handle = succ_ff[HANDLE_WIDTH-1:0];
   assign idx_next    = idx_ff + ONE;
   assign sh_dec      = sh_ff - ONE;
   assign merge_sum   = {1'b0, cur_delta} + {1'b0, succ_delta};
   assign merge_sat   = merge_sum[TICK_WIDTH] ? '1 : merge_sum[TICK_WIDTH-1:0];

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      hnd_in        = hnd_ff;
      delay_in      = delay_ff;
      idx_in        = idx_ff;
      sh_in         = sh_ff;
      cnt_in        = cnt_ff;
      succ_in       = succ_ff;
      link_in       = link_ff;
      rel_in        = rel_ff;
      relh_in       = relh_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_rel_in    = rsp_rel_ff;
      rsp_relh_in   = rsp_relh_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[IDX_W-1:0];
      ram_wdata     = '0;
      ram_raddr     = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = op_type'(req_operation);
               hnd_in    = req_handle;
               delay_in  = req_delay_ticks;
               idx_in    = '0;
               link_in   = 1'b0;
               rel_in    = 1'b0;
               relh_in   = '0;
               status_in = STATUS_OK;
               if (op_type'(req_operation) == OP_ADD && cnt_ff == CAP_CNT) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_DONE;
               end else if (op_type'(req_operation) == OP_ADD && cnt_ff == '0) begin
                  state_in = ST_INSERT;
               end else if (cnt_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            case (op_ff)
               OP_ADD: begin
                  if (delay_ff >= cur_delta) begin
                     delay_in = delay_ff - cur_delta;
                     idx_in   = idx_next;
                     state_in = (idx_next < cnt_ff) ? ST_READ : ST_INSERT;
                  end else begin
                     succ_in  = ram_rdata;
                     link_in  = 1'b1;
                     sh_in    = cnt_ff;
                     state_in = ST_UP_RD;
                  end
               end
               OP_TICK: begin
                  if (cur_delta <= TICK_ONE) begin
                     rel_in   = 1'b1;
                     relh_in  = cur_handle;
                     sh_in    = ONE;
                     state_in = ST_DN_RD;
                  end else begin
                     ram_we    = 1'b1;
                     ram_wdata = {cur_delta - TICK_ONE, cur_handle};
                     state_in  = ST_DONE;
                  end
               end
               OP_TAKE_DUE: begin
                  if (cur_delta == '0) begin
                     rel_in   = 1'b1;
                     relh_in  = cur_handle;
                     sh_in    = ONE;
                     state_in = ST_DN_RD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  // remove: linear search for the first matching handle
                  if (cur_handle == hnd_ff) begin
                     if (idx_next < cnt_ff) begin
                        succ_in   = ram_rdata;
                        ram_raddr = idx_next[IDX_W-1:0];
                        state_in  = ST_MERGE;
                     end else begin
                        cnt_in   = cnt_ff - ONE;
                        state_in = ST_DONE;
                     end
                  end else if (idx_next < cnt_ff) begin
                     idx_in   = idx_next;
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            endcase
         end
         ST_UP_RD: begin
            if (sh_ff > idx_next) begin
               ram_raddr = sh_dec[IDX_W-1:0];
               state_in  = ST_UP_WR;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_UP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = sh_ff[IDX_W-1:0];
            ram_wdata = ram_rdata;
            sh_in     = sh_dec;
            state_in  = ST_UP_RD;
         end
         ST_INSERT: begin
            ram_we = 1'b1;
            if (link_ff) begin
               // successor keeps the remainder of its deadline
               ram_waddr = idx_next[IDX_W-1:0];
               ram_wdata = {succ_delta - delay_ff, succ_handle};
               link_in   = 1'b0;
            end else begin
               ram_wdata = {delay_ff, hnd_ff};
               cnt_in    = cnt_ff + ONE;
               state_in  = ST_DONE;
            end
         end
         ST_MERGE: begin
            // removed entry's delta folds into its successor, saturating
            ram_we    = 1'b1;
            ram_wdata = {merge_sat, cur_handle};
            sh_in     = idx_ff + TWO;
            state_in  = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (sh_ff < cnt_ff) begin
               ram_raddr = sh_ff[IDX_W-1:0];
               state_in  = ST_DN_WR;
            end else begin
               cnt_in   = cnt_ff - ONE;
               state_in = ST_DONE;
            end
         end
         ST_DN_WR: begin
            ram_we    = 1'b1;
            ram_waddr = sh_dec[IDX_W-1:0];
            ram_wdata = ram_rdata;
            sh_in     = sh_ff + ONE;
            state_in  = ST_DN_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_rel_in    = rel_ff;
               rsp_relh_in   = relh_ff;
               rsp_status_in = status_ff;
               rsp_cnt_in    = cnt_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      hnd_ff        <= hnd_in;
      delay_ff      <= delay_in;
      idx_ff        <= idx_in;
      sh_ff         <= sh_in;
      succ_ff       <= succ_in;
      link_ff       <= link_in;
      rel_ff        <= rel_in;
      relh_ff       <= relh_in;
      status_ff     <= status_in;
      rsp_rel_ff    <= rsp_rel_in;
      rsp_relh_ff   <= rsp_relh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_released        = rsp_rel_ff;
   assign rsp_released_handle = rsp_relh_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_count     = rsp_cnt_ff;
   assign rsp_queue_empty     = (rsp_cnt_ff == '0);

endmodule

### rtl/dtq_checker.sv
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks of the delta timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "delta_timer_queue_macros.svh"

module dtq_checker
   import dtq_pkg::*;
#(
   parameter int CAPACITY     = 32,
   parameter int TICK_WIDTH   = 32,
   parameter int HANDLE_WIDTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_released,
   input logic [HANDLE_WIDTH-1:0]       rsp_released_handle,
   input logic                          rsp_status,
   input logic                          rsp_queue_empty,
   input logic [$clog2(CAPACITY+1)-1:0] rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // accepted request keeps the input busy for the next cycle
   `DTQ_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall)

   // stalled word holds
   `DTQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_released_handle) && $stable(rsp_entry_count))

   // empty flag agrees with the count
   `DTQ_ASSERT_IMPLY(a_empty_cnt, clock, reset, rsp_valid, rsp_queue_empty == (rsp_entry_count == '0))

   // no handle shown without a release
   `DTQ_ASSERT_IMPLY(a_rel_zero, clock, reset, rsp_valid && !rsp_released, rsp_released_handle == '0)

   // refused add only at capacity, never with a release
   `DTQ_ASSERT_IMPLY(a_full, clock, reset, rsp_valid && rsp_status == STATUS_FULL, rsp_entry_count == CNT_W'(CAPACITY) && !rsp_released)

endmodule

bind delta_timer_queue dtq_checker #(
   .CAPACITY     (CAPACITY),
   .TICK_WIDTH   (TICK_WIDTH),
   .HANDLE_WIDTH (HANDLE_WIDTH)
) u_dtq_checker (.*);
